// ===== sv/tts_pkg.sv =====
// Shared types, request codes and tick-base tables for the tick timebase stopwatch.
// No dependencies; every other file imports this package.
`default_nettype none

package tts_pkg;

    // Clock cycles per microsecond of the system clock.
    localparam int CLOCKS_PER_US = 42;

    // Widths of the state and of the microseconds-per-tick table.
    localparam int PRESCALE_W = 26;
    localparam int COUNT_W    = 32;
    localparam int US_W       = 20;
    localparam int BASE_W     = 3;
    localparam int REQ_W      = 3;

    // Request codes; six and seven are unused; they change no state and return zero.
    localparam logic [REQ_W-1:0] REQ_STEP  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELTA = 3'd2;
    localparam logic [REQ_W-1:0] REQ_START = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STOP  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CONV  = 3'd5;

    // Tick base codes.
    localparam logic [BASE_W-1:0] BASE_1US    = 3'd0;
    localparam logic [BASE_W-1:0] BASE_10US   = 3'd1;
    localparam logic [BASE_W-1:0] BASE_100US  = 3'd2;
    localparam logic [BASE_W-1:0] BASE_1MS    = 3'd3;
    localparam logic [BASE_W-1:0] BASE_10MS   = 3'd4;
    localparam logic [BASE_W-1:0] BASE_100MS  = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COUNT_W-1:0] tick_value;
    } tts_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] result_value;
        logic               tick_event;
    } tts_out_t;

    // Input register contents handed to the execute stage.
    typedef struct packed {
        logic    valid;
        tts_in_t item;
    } tts_slot_t;

    // Microseconds per tick; the unused codes behave as 1000 ms.
    function automatic logic [US_W-1:0] us_per_tick(input logic [BASE_W-1:0] base);
        logic [US_W-1:0] us;
        case (base)
            BASE_1US:   us = US_W'(1);
            BASE_10US:  us = US_W'(10);
            BASE_100US: us = US_W'(100);
            BASE_1MS:   us = US_W'(1000);
            BASE_10MS:  us = US_W'(10000);
            BASE_100MS: us = US_W'(100000);
            default:    us = US_W'(1000000);
        endcase
        return us;
    endfunction

    // Clock steps per tick period, from constants only.
    function automatic logic [PRESCALE_W-1:0] period_clocks(input logic [BASE_W-1:0] base);
        logic [PRESCALE_W-1:0] p;
        case (base)
            BASE_1US:   p = PRESCALE_W'(CLOCKS_PER_US * 1);
            BASE_10US:  p = PRESCALE_W'(CLOCKS_PER_US * 10);
            BASE_100US: p = PRESCALE_W'(CLOCKS_PER_US * 100);
            BASE_1MS:   p = PRESCALE_W'(CLOCKS_PER_US * 1000);
            BASE_10MS:  p = PRESCALE_W'(CLOCKS_PER_US * 10000);
            BASE_100MS: p = PRESCALE_W'(CLOCKS_PER_US * 100000);
            default:    p = PRESCALE_W'(CLOCKS_PER_US * 1000000);
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tts_in_reg.sv =====
// Input register stage of the tick timebase stopwatch.
// Depends on tts_pkg for the request and slot types.
`default_nettype none

module tts_in_reg (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              req_valid,
    output logic             req_stall,
    input  tts_pkg::tts_in_t req,
    input  wire              advance,
    output tts_pkg::tts_slot_t slot
);
    import tts_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    tts_in_t item_reg;
    logic    load;

    // Hold only while the execute stage cannot take the held transaction.
    assign req_stall = valid_reg && !advance;
    assign load      = req_valid && !req_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= req;
        end
    end

    assign slot = {valid_reg, item_reg};

endmodule

`default_nettype wire

// ===== sv/tts_exec.sv =====
// Execute stage: timebase state, request decode and the result register.
// Depends on tts_pkg for types, request codes and tick-base tables.
`default_nettype none

module tts_exec (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_write_en,
    input  wire [tts_pkg::BASE_W-1:0]      cfg_write_data,
    input  tts_pkg::tts_slot_t             slot,
    output logic                           advance,
    output logic                           rsp_valid,
    input  wire                            rsp_stall,
    output tts_pkg::tts_out_t              rsp
);
    import tts_pkg::*;

    logic [BASE_W-1:0]     base_reg;
    logic [BASE_W-1:0]     base_next;
    logic [PRESCALE_W-1:0] prescale_reg;
    logic [PRESCALE_W-1:0] prescale_next;
    logic [COUNT_W-1:0]    tick_reg;
    logic [COUNT_W-1:0]    tick_next;
    logic [COUNT_W-1:0]    mark_reg;
    logic [COUNT_W-1:0]    mark_next;
    logic [COUNT_W-1:0]    cap_reg;
    logic [COUNT_W-1:0]    cap_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    tts_out_t              out_reg;
    tts_out_t              out_next;

    logic [PRESCALE_W:0]       step_sum;
    logic                      period_done;
    logic [COUNT_W+US_W-1:0]   conv_prod;

    assign advance = slot.valid && (!out_valid_reg || !rsp_stall);

    assign step_sum    = {1'b0, prescale_reg} + (PRESCALE_W+1)'(1);
    assign period_done = step_sum >= {1'b0, period_clocks(base_reg)};
    assign conv_prod   = {{US_W{1'b0}}, slot.item.tick_value}
                       * {{COUNT_W{1'b0}}, us_per_tick(base_reg)};

    always_comb
    begin
        base_next     = base_reg;
        prescale_next = prescale_reg;
        tick_next     = tick_reg;
        mark_next     = mark_reg;
        cap_next      = cap_reg;
        out_next      = '0;

        if (advance)
        begin
            case (slot.item.req_type)
                REQ_STEP:
                begin
                    if (period_done)
                    begin
                        prescale_next       = '0;
                        tick_next           = tick_reg + COUNT_W'(1);
                        out_next.tick_event = 1'b1;
                    end
                    else
                    begin
                        prescale_next = step_sum[PRESCALE_W-1:0];
                    end
                end
                REQ_READ:
                begin
                    out_next.result_value = tick_reg;
                end
                REQ_DELTA:
                begin
                    out_next.result_value = tick_reg - mark_reg;
                    mark_next             = tick_reg;
                end
                REQ_START:
                begin
                    cap_next              = tick_reg;
                    out_next.result_value = tick_reg;
                end
                REQ_STOP:
                begin
                    out_next.result_value = tick_reg - cap_reg;
                end
                REQ_CONV:
                begin
                    out_next.result_value = conv_prod[COUNT_W-1:0];
                end
                default:
                begin
                    out_next = '0;
                end
            endcase
        end

        // Config must only arrive while idle; the block does not enforce it. It resets the running count.
        if (cfg_write_en)
        begin
            base_next     = cfg_write_data;
            prescale_next = '0;
            tick_next     = '0;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            prescale_reg  <= '0;
            tick_reg      <= '0;
            mark_reg      <= '0;
            cap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            prescale_reg  <= prescale_next;
            tick_reg      <= tick_next;
            mark_reg      <= mark_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// ===== sv/tick_timebase_stopwatch.sv =====
// Top level of the tick timebase stopwatch: input register plus execute stage.
// Depends on tts_pkg, tts_in_reg and tts_exec.
//
//   channel   handshake                  payload
//   -------   -------------------------  -----------------------------------
//   req       req_valid / req_stall      tts_in_t  {req_type, tick_value}
//   rsp       rsp_valid / rsp_stall      tts_out_t {result_value, tick_event}
//   cfg       cfg_write_en               cfg_write_data = tick_base
//
// One transaction per cycle is accepted and one result per cycle delivered
// while rsp_stall is low. A request passes the input register, then the result
// register; the state update, decode and the 32x20 conversion multiply sit between
// them. rsp_stall holds the result register; req_stall rises only while both the
// result and input registers are full and rsp_stall is high.
// Reset (rst_n low, asynchronous) clears the tick base, all counters and marks.
`default_nettype none

module tick_timebase_stopwatch (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        req_valid,
    output logic                       req_stall,
    input  tts_pkg::tts_in_t           req,
    output logic                       rsp_valid,
    input  wire                        rsp_stall,
    output tts_pkg::tts_out_t          rsp,
    input  wire                        cfg_write_en,
    input  wire [tts_pkg::BASE_W-1:0]  cfg_write_data
);
    import tts_pkg::*;

    tts_slot_t slot;
    logic      advance;

    // Input register: parts the request side from the result register.
    tts_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .advance   (advance),
        .slot      (slot)
    );

    // Timebase state, request decode and result register.
    tts_exec u_exec (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .slot           (slot),
        .advance        (advance),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp)
    );

endmodule

`default_nettype wire

// ===== sv/tts_checker.sv =====
// Port-level checker for the tick timebase stopwatch, bound to the top level.
// Depends on tts_pkg for the payload types.
`default_nettype none

module tts_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               req_valid,
    input wire               req_stall,
    input tts_pkg::tts_in_t  req,
    input wire               rsp_valid,
    input wire               rsp_stall,
    input tts_pkg::tts_out_t rsp
);
    import tts_pkg::*;

    // A stalled result stays and keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // A tick event comes only from a clock step, whose value is zero.
    a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.tick_event |-> rsp.result_value == '0)
        else $error("tick event with nonzero value");

    // Request side backs up only when the result side is stalled and full.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without result back-pressure");

    // A result appearing from empty comes from a request accepted through the input register.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
        else $error("result without an accepted request");

endmodule

bind tick_timebase_stopwatch tts_checker u_tts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// ===== dv/tick_timebase_stopwatch_tb.sv =====
// Self-checking testbench for the tick timebase stopwatch: directed and random requests,
// checked against an in-bench model of the prescaler, tick counter and stopwatch marks.
// Depends on tts_pkg and the tick_timebase_stopwatch RTL only.
`default_nettype none

module tick_timebase_stopwatch_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    // Request and tick-base codes that the package leaves unnamed.
    localparam logic [REQ_W-1:0]  REQ_SPARE6    = 3'd6;
    localparam logic [REQ_W-1:0]  REQ_SPARE7    = 3'd7;
    localparam logic [BASE_W-1:0] BASE_1S       = 3'd6;
    localparam logic [BASE_W-1:0] BASE_1S_ALIAS = 3'd7;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int MAX_IDLE      = 14;
    localparam int DRAIN_CYCLES  = 8;    // two-stage pipe plus margin
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 60;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 20;
    localparam int TIMEOUT_NS    = 5_000_000;

    // DUT ports; every input has a known value from time zero.
    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                req_valid      = 1'b0;
    logic                req_stall;
    tts_in_t             req            = '0;
    logic                rsp_valid;
    logic                rsp_stall      = 1'b0;
    tts_out_t            rsp;
    logic                cfg_write_en   = 1'b0;
    logic [BASE_W-1:0]   cfg_write_data = '0;

    // Mirror of the block's state as the testbench expects it.
    logic [BASE_W-1:0]   model_base     = BASE_1US;
    longint unsigned     model_prescale = 0;
    logic [COUNT_W-1:0]  model_ticks    = '0;
    logic [COUNT_W-1:0]  model_mark     = '0;
    logic [COUNT_W-1:0]  model_capture  = '0;

    // Responses predicted at request acceptance, oldest first.
    tts_out_t            awaited_responses [$];

    // Idle control: the test sequence flips these per phase.
    bit                  req_idle_on    = 1'b1;
    bit                  rsp_idle_on    = 1'b1;

    // Long receiver hold-off: the sequence bumps hold_serial, the receiver notices.
    int                  hold_serial    = 0;
    int                  hold_seen      = 0;
    int                  hold_left      = 0;
    int                  stall_left     = 0;

    int                  failures       = 0;
    int                  sent_items     = 0;
    int                  results_seen   = 0;
    int                  ticks_seen     = 0;
    int                  stalled_offers = 0;

    tick_timebase_stopwatch u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Microseconds in one tick; the spare codes run as the 1 s base.
    function automatic int unsigned tick_us(input logic [BASE_W-1:0] base);
        int unsigned us;
        case (base)
            BASE_1US:   us = 1;
            BASE_10US:  us = 10;
            BASE_100US: us = 100;
            BASE_1MS:   us = 1000;
            BASE_10MS:  us = 10000;
            BASE_100MS: us = 100000;
            default:    us = 1000000;
        endcase
        return us;
    endfunction

    function automatic longint unsigned tick_period(input logic [BASE_W-1:0] base);
        return longint'(CLOCKS_PER_US) * longint'(tick_us(base));
    endfunction

    // Response to one accepted transaction; advances the mirrored state.
    function automatic tts_out_t timebase_response(input tts_in_t item);
        tts_out_t res;
        res = '0;
        case (item.req_type)
            REQ_STEP:
            begin
                if (model_prescale + 1 >= tick_period(model_base))
                begin
                    model_prescale = 0;
                    model_ticks    = model_ticks + 1'b1;
                    res.tick_event = 1'b1;
                end
                else
                begin
                    model_prescale = model_prescale + 1;
                end
            end
            REQ_READ:
                res.result_value = model_ticks;
            REQ_DELTA:
            begin
                // single snapshot: result and new mark come from the same count
                res.result_value = model_ticks - model_mark;
                model_mark       = model_ticks;
            end
            REQ_START:
            begin
                model_capture    = model_ticks;
                res.result_value = model_capture;
            end
            REQ_STOP:
                res.result_value = model_ticks - model_capture;
            REQ_CONV:
                res.result_value = COUNT_W'(item.tick_value * tick_us(model_base));
            default:
                ;   // spare codes: no state change, zero response
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Response side: random stalls, one long hold-off, and the checker.
    // Everything is sampled at the rising edge before any NBA lands, so
    // the accept condition sees the same values the DUT does.
    // ------------------------------------------------------------------

    task automatic score_response(input tts_out_t got);
        tts_out_t want;
        results_seen++;
        if (got.tick_event === 1'b1)
            ticks_seen++;
        if (awaited_responses.size() == 0)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("[%0t] response with nothing awaited: value %h event %b",
                         $realtime, got.result_value, got.tick_event);
        end
        else
        begin
            want = awaited_responses.pop_front();
            if (got.result_value !== want.result_value || got.tick_event !== want.tick_event)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"[%0t] response mismatch: expected value %h event %b,",
                              " got value %h event %b"},
                             $realtime, want.result_value, want.tick_event,
                             got.result_value, got.tick_event);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            score_response(rsp);
            stall_left = rsp_idle_on ? $urandom_range(MAX_IDLE) : 0;
        end
        if (hold_serial != hold_seen)
        begin
            hold_seen = hold_serial;
            hold_left = HOLD_CYCLES;
        end
        // exactly one NBA to rsp_stall per edge
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Request side. Every task here starts and ends right after a rising
    // edge; valid stays high between back-to-back transactions.
    // ------------------------------------------------------------------

    task automatic send_request(input logic [REQ_W-1:0] code, input logic [COUNT_W-1:0] value);
        tts_in_t item;
        int      gap;
        item.req_type   = code;
        item.tick_value = value;
        gap = req_idle_on ? $urandom_range(MAX_IDLE) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
            stalled_offers++;
        end
        awaited_responses.push_back(timebase_response(item));
        sent_items++;
    endtask

    task automatic send_steps(input int count);
        repeat (count) send_request(REQ_STEP, $urandom());
    endtask

    // Drop valid and let the pipe empty; every transaction gives one response,
    // so an empty queue plus the pipe depth means nothing is in flight.
    task automatic wait_until_idle();
        req_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A tick_base write clears prescaler and count but keeps delta mark and capture.
    task automatic apply_tick_base(input logic [BASE_W-1:0] base);
        wait_until_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= base;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        model_base     = base;
        model_prescale = 0;
        model_ticks    = '0;
    endtask

    function automatic logic [REQ_W-1:0] random_request_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)      return REQ_STEP;
        else if (pick < 71) return REQ_READ;
        else if (pick < 77) return REQ_DELTA;
        else if (pick < 83) return REQ_START;
        else if (pick < 89) return REQ_STOP;
        else if (pick < 97) return REQ_CONV;
        else if (pick < 98) return REQ_SPARE6;
        else                return REQ_SPARE7;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh out of reset: every read is zero, stop without a start measures
    // from zero, conversion extremes, spare codes leave the state alone.
    task automatic test_power_on_requests();
        send_request(REQ_READ,   $urandom());
        send_request(REQ_DELTA,  $urandom());
        send_request(REQ_STOP,   $urandom());
        send_request(REQ_CONV,   32'h0000_0000);
        send_request(REQ_CONV,   32'hFFFF_FFFF);
        send_request(REQ_CONV,   32'h0000_0001);
        send_request(REQ_CONV,   32'hAAAA_AAAA);
        send_request(REQ_CONV,   32'h5555_5555);
        send_request(REQ_SPARE6, 32'hFFFF_FFFF);
        send_request(REQ_SPARE7, 32'hFFFF_FFFF);
        send_request(REQ_START,  $urandom());
        send_request(REQ_READ,   $urandom());
    endtask

    // Every tick base, both ends included; the spare codes must act as 1 s.
    task automatic test_tick_bases();
        logic [BASE_W-1:0] all_bases [8] = '{BASE_1US, BASE_10US, BASE_100US, BASE_1MS,
                                             BASE_10MS, BASE_100MS, BASE_1S, BASE_1S_ALIAS};
        foreach (all_bases[i])
        begin
            apply_tick_base(all_bases[i]);
            send_request(REQ_CONV, 32'hFFFF_FFFF);
            send_request(REQ_CONV, $urandom());
            send_request(REQ_STEP, $urandom());
        end
        apply_tick_base(BASE_1US);
    endtask

    // Ticks on the 1 us base, capture and delta across them, and the tick
    // landing exactly on the last step of a period.
    task automatic test_tick_and_stopwatch();
        send_request(REQ_START, $urandom());
        send_steps(CLOCKS_PER_US * 2);
        send_request(REQ_READ,  $urandom());
        send_request(REQ_STOP,  $urandom());
        send_request(REQ_DELTA, $urandom());
        send_steps(CLOCKS_PER_US - 1);
        send_request(REQ_READ,  $urandom());
        send_steps(1);
        send_request(REQ_DELTA, $urandom());
        send_request(REQ_START, $urandom());
        send_request(REQ_STOP,  $urandom());
    endtask

    // Rebase mid-period: count and prescaler restart, marks stay, so delta
    // and elapsed go negative and wrap.
    task automatic test_rebase_keeps_marks();
        send_steps(CLOCKS_PER_US + 17);
        send_request(REQ_DELTA, $urandom());
        send_request(REQ_START, $urandom());
        apply_tick_base(BASE_1US);
        send_request(REQ_READ,  $urandom());
        send_request(REQ_DELTA, $urandom());
        send_request(REQ_STOP,  $urandom());
        send_steps(CLOCKS_PER_US - 1);
        send_request(REQ_READ,  $urandom());
        send_steps(1);
        send_request(REQ_STOP,  $urandom());
        apply_tick_base(BASE_1US);
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    // back to back, so both pipe stages fill and req_stall must rise.
    task automatic test_stall_pressure();
        req_idle_on = 1'b0;
        hold_serial++;
        repeat (HOLD_CYCLES + 20) send_request(random_request_code(), $urandom());
        req_idle_on = 1'b1;
    endtask

    // Random mix on the short bases; each phase uses its own pair of idle
    // modes so both full-rate and gappy traffic are seen on each side.
    task automatic test_random_traffic();
        int pick;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick = $urandom_range(3);
            if (pick < 2)
                apply_tick_base(BASE_1US);
            else if (pick == 2)
                apply_tick_base(BASE_10US);
            else
                apply_tick_base(BASE_100US);
            req_idle_on = phase[0];
            rsp_idle_on = phase[1];
            repeat (PHASE_ITEMS) send_request(random_request_code(), $urandom());
        end
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_power_on_requests();
        test_tick_bases();
        test_tick_and_stopwatch();
        test_rebase_keeps_marks();
        test_stall_pressure();
        test_random_traffic();

        wait_until_idle();
        if (awaited_responses.size() != 0)
            failures++;

        $display("Covered %0d transactions and %0d responses, %0d tick events,",
                 sent_items, results_seen, ticks_seen);
        $display("all eight tick bases, a mid-period rebase and %0d stalled request cycles.",
                 stalled_offers);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
